// ===== rtl/wtp_pkg.sv =====
// Shared types and constants for the waypoint turn-drive-turn planner.
// Depends on nothing; the planner top level imports it.
package wtp_pkg;

    // Field widths of the request and result.
    localparam int X_W      = 11;
    localparam int Y_W      = 12;
    localparam int H_W      = 9;
    localparam int TURN_W   = 16;
    localparam int DIST_W   = 14;

    // Internal datapath widths.
    localparam int DX_W     = 12;
    localparam int DY_W     = 13;
    localparam int DXSQ_W   = 24;
    localparam int DYSQ_W   = 26;
    localparam int SQ_W     = 26;
    localparam int ROOT_W   = 13;
    localparam int SQRT_TOP = 24;

    // CORDIC vectoring pass.
    localparam int CORDIC_W     = 32;
    localparam int CORDIC_FRAC  = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;

    // Heading conversion: hundredths of a radian to a 32-bit binary angle.
    localparam int       PROD_W      = 33;
    localparam logic [22:0] HEADING_K32 = 23'd6835653;

    // Arctangent table, 2^32 equals one full turn.
    localparam logic [CORDIC_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Sequencer states.
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PREP = 7'b0000010,
        S_INIT = 7'b0000100,
        S_ITER = 7'b0001000,
        S_FOLD = 7'b0010000,
        S_TURN = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

endpackage

// ===== rtl/waypoint_turn_drive_turn_planner.sv =====
// Waypoint planner top level: turn, drive straight, turn for a two-wheel robot.
// Uses wtp_pkg for widths, the arctangent table and the sequencer states.
//
//   channel   direction  handshake           payload
//   request   in         i_valid / o_stall   i_cmd, i_target_x, i_target_y, i_target_heading
//   result    out        o_valid / i_stall   o_first_turn, o_travel_distance,
//                                            o_second_turn, o_will_move
//
// A move request passes from acceptance to a valid result through the
// differences and squares, the setup, 24 iterations of the shared CORDIC
// shift-add unit (the square root runs beside it), the turn fold, the final
// turn and the result register. A start-pose request goes from the differences
// straight to the result register. One request is in work at a time; o_stall is high while it is.
// The result register holds while i_stall is high, and a new request is taken
// meanwhile. Synchronous active-low reset clears the pose and the sequencer.
module waypoint_turn_drive_turn_planner
    import wtp_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_cmd,
    input  logic [X_W-1:0]           i_target_x,
    input  logic [Y_W-1:0]           i_target_y,
    input  logic [H_W-1:0]           i_target_heading,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [TURN_W-1:0] o_first_turn,
    output logic signed [DIST_W-1:0] o_travel_distance,
    output logic signed [TURN_W-1:0] o_second_turn,
    output logic                     o_will_move
);

    localparam int AB = ANGLE_BITS;
    localparam logic signed [AB-1:0] A_QUARTER     = AB'(1) << (AB - 2);
    localparam logic signed [AB-1:0] A_QUARTER_NEG = -A_QUARTER;
    localparam logic signed [AB-1:0] A_HALF        = AB'(1) << (AB - 1);
    localparam logic [AB-1:0]        A_THREE_Q     = AB'(3) << (AB - 2);
    localparam logic [CORDIC_W-1:0]  Z_ROUND       = CORDIC_W'(1) << (31 - AB);
    localparam logic [PROD_W-1:0]    H_ROUND       = PROD_W'(1) << (31 - AB);

    t_state r_state, n_state;

    // Pose state.
    logic [X_W-1:0] r_last_x;
    logic [Y_W-1:0] r_last_y;
    logic [AB-1:0]  r_heading;

    // Captured request.
    logic           r_cmd;
    logic [X_W-1:0] r_tx;
    logic [Y_W-1:0] r_ty;
    logic [H_W-1:0] r_h;

    // Working registers.
    logic signed [DX_W-1:0]     r_dx;
    logic signed [DY_W-1:0]     r_dy;
    logic [DXSQ_W-1:0]          r_dxsq;
    logic [DYSQ_W-1:0]          r_dysq;
    logic [AB-1:0]              r_want;
    logic                       r_dx_zero;
    logic                       r_dy_pos;
    logic signed [CORDIC_W-1:0] r_cx, r_cy;
    logic [CORDIC_W-1:0]        r_cz;
    logic [STEP_W-1:0]          r_step;
    logic [SQ_W-1:0]            r_rem, r_root, r_bit;
    logic signed [AB-1:0]       r_t1, r_t2;
    logic signed [DIST_W-1:0]   r_dist;

    // Output register.
    logic                       r_o_valid;
    logic signed [TURN_W-1:0]   r_first_turn, r_second_turn;
    logic signed [DIST_W-1:0]   r_travel_distance;
    logic                       r_will_move;

    // Combinational helpers.
    logic signed [DX_W-1:0]     dx;
    logic signed [DY_W-1:0]     dy;
    logic [PROD_W-1:0]          hprod;
    logic signed [CORDIC_W-1:0] x0, y0, xs, ys;
    logic [SQ_W-1:0]            sq_trial;
    logic [CORDIC_W-1:0]        zsum;
    logic [AB-1:0]              traj;
    logic signed [AB-1:0]       diff;
    logic                       fold;
    logic signed [DIST_W-1:0]   root_dist;
    logic                       out_free;
    logic                       req_accept;

    assign req_accept = i_valid && (r_state == S_IDLE);
    assign out_free   = !r_o_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE);

    // Differences, heading conversion and CORDIC start values.
    always_comb begin
        dx    = $signed({1'b0, r_tx}) - $signed({1'b0, r_last_x});
        dy    = $signed({1'b0, r_ty}) - $signed({1'b0, r_last_y});
        hprod = PROD_W'(r_h) * PROD_W'(HEADING_K32) + H_ROUND;
        x0    = CORDIC_W'(r_dx) <<< CORDIC_FRAC;
        y0    = CORDIC_W'(r_dy) <<< CORDIC_FRAC;
        xs    = r_cx >>> r_step;
        ys    = r_cy >>> r_step;
        sq_trial = r_root + r_bit;
    end

    // Trajectory angle rounding and the first-turn fold.
    always_comb begin
        zsum = r_cz + Z_ROUND;
        if (r_dx_zero) begin
            traj = r_dy_pos ? AB'(A_QUARTER) : A_THREE_Q;
        end else begin
            traj = zsum[31 -: AB];
        end
        diff      = $signed(traj - r_heading);
        fold      = (diff >= A_QUARTER) || (diff <= A_QUARTER_NEG);
        root_dist = $signed(DIST_W'(r_root[ROOT_W-1:0]));
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_PREP;
            S_PREP: n_state = r_cmd ? S_INIT : S_DONE;
            S_INIT: n_state = S_ITER;
            S_ITER: if (r_step == STEP_W'(CORDIC_STEPS - 1)) n_state = S_FOLD;
            S_FOLD: n_state = S_TURN;
            S_TURN: n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_last_x  <= '0;
            r_last_y  <= '0;
            r_heading <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
                r_last_x  <= r_tx;
                r_last_y  <= r_ty;
                r_heading <= r_want;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_cmd <= i_cmd;
            r_tx  <= i_target_x;
            r_ty  <= i_target_y;
            r_h   <= i_target_heading;
        end

        case (r_state)
            // Differences, squares and the desired heading.
            S_PREP: begin
                r_dx      <= dx;
                r_dy      <= dy;
                r_dxsq    <= DXSQ_W'(dx * dx);
                r_dysq    <= DYSQ_W'(dy * dy);
                r_want    <= hprod[31 -: AB];
                r_dx_zero <= (dx == '0);
                r_dy_pos  <= (dy > 0);
                r_t1      <= '0;
                r_t2      <= '0;
                r_dist    <= '0;
            end
            // Start the square root and the CORDIC pass.
            S_INIT: begin
                r_rem  <= SQ_W'(r_dxsq) + r_dysq;
                r_root <= '0;
                r_bit  <= SQ_W'(1) << SQRT_TOP;
                r_step <= '0;
                if (r_dx < 0) begin
                    r_cx <= -x0;
                    r_cy <= -y0;
                    r_cz <= 32'h8000_0000;
                end else begin
                    r_cx <= x0;
                    r_cy <= y0;
                    r_cz <= '0;
                end
            end
            // One CORDIC rotation and one square-root digit per cycle.
            S_ITER: begin
                r_step <= r_step + STEP_W'(1);
                if (!r_cy[CORDIC_W-1]) begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + ATAN_TAB[r_step];
                end else begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - ATAN_TAB[r_step];
                end
                if (r_bit != '0) begin
                    if (r_rem >= sq_trial) begin
                        r_rem  <= r_rem - sq_trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
            end
            // First turn, folded by a half turn when the robot drives backward.
            S_FOLD: begin
                if (diff >= A_QUARTER) begin
                    r_t1 <= diff - A_HALF;
                end else if (diff <= A_QUARTER_NEG) begin
                    r_t1 <= diff + A_HALF;
                end else begin
                    r_t1 <= diff;
                end
                r_dist <= fold ? -root_dist : root_dist;
            end
            // Final turn to the desired heading.
            S_TURN: begin
                r_t2 <= $signed(r_want - r_t1 - r_heading);
            end
            // Result register load.
            S_DONE: begin
                if (out_free) begin
                    r_first_turn      <= TURN_W'(r_t1);
                    r_second_turn     <= TURN_W'(r_t2);
                    r_travel_distance <= r_dist;
                    r_will_move       <= (r_t1 != '0) || (r_dist != '0) || (r_t2 != '0);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid           = r_o_valid;
    assign o_first_turn      = r_first_turn;
    assign o_travel_distance = r_travel_distance;
    assign o_second_turn     = r_second_turn;
    assign o_will_move       = r_will_move;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for waypoint_turn_drive_turn_planner.
// Drives waypoint requests, predicts each turn-drive-turn plan in place and checks
// every result in order. Depends only on wtp_pkg and the planner RTL.
module tb
    import wtp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Request command codes.
    localparam logic CMD_SET_POSE = 1'b0;
    localparam logic CMD_MOVE     = 1'b1;

    // Binary angles, one full turn is 2^16 (2^32 for the CORDIC accumulator).
    localparam logic [15:0] QUARTER_TURN       = 16'h4000;
    localparam logic [15:0] THREE_QUARTER_TURN = 16'hC000;
    localparam logic [31:0] HALF_TURN_32       = 32'h8000_0000;
    localparam int          QUARTER            = 16384;
    localparam int          HALF               = 32768;

    // Arctangent of 2^-i, 2^32 equals one full turn.
    localparam logic [31:0] ARC_STEP [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    localparam int RANDOM_REQUESTS = 1380;
    localparam int HOLD_CYCLES     = 250;
    localparam int DRAIN_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT  = 3000;

    typedef struct {
        logic           cmd;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic [H_W-1:0] heading;
    } t_waypoint;

    typedef struct {
        logic signed [TURN_W-1:0] first_turn;
        logic signed [DIST_W-1:0] travel_distance;
        logic signed [TURN_W-1:0] second_turn;
        logic                     will_move;
    } t_plan;

    typedef struct {
        t_waypoint wp;
        logic      typed;  // the plan below is written out by hand
        t_plan     plan;
    } t_stim_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic                     i_cmd = CMD_SET_POSE;
    logic [X_W-1:0]           i_target_x = '0;
    logic [Y_W-1:0]           i_target_y = '0;
    logic [H_W-1:0]           i_target_heading = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [TURN_W-1:0] o_first_turn;
    logic signed [DIST_W-1:0] o_travel_distance;
    logic signed [TURN_W-1:0] o_second_turn;
    logic                     o_will_move;

    // Predictor pose, updated at each accepted request.
    logic [X_W-1:0] pose_x = '0;
    logic [Y_W-1:0] pose_y = '0;
    logic [15:0]    pose_heading = '0;

    t_plan planned_q [$];
    int    mismatches = 0;
    int    quiet_cycles = 0;
    int    holds_asked = 0;
    int    holds_done = 0;
    bit    calm = 1'b0;

    // Directed requests: extremes, both commands, zero moves, axis-aligned moves.
    t_stim_row directed_rows [21] = '{
        // Zero move right after reset: the 3*pi/2 trajectory folds to a quarter turn.
        '{'{CMD_MOVE, 11'd0, 12'd0, 9'd0}, 1'b1,
          '{16'sd16384, 14'sd0, -16'sd16384, 1'b1}},
        // Straight up with heading zero: folds and drives backward.
        '{'{CMD_MOVE, 11'd0, 12'd100, 9'd0}, 1'b1,
          '{-16'sd16384, -14'sd100, 16'sd16384, 1'b1}},
        // Straight down: trajectory 3*pi/2, folds and drives backward.
        '{'{CMD_MOVE, 11'd0, 12'd0, 9'd0}, 1'b1,
          '{16'sd16384, -14'sd100, -16'sd16384, 1'b1}},
        '{'{CMD_SET_POSE, 11'd2047, 12'd4095, 9'd511}, 1'b1, '{16'sd0, 14'sd0, 16'sd0, 1'b0}},
        '{'{CMD_SET_POSE, 11'd0, 12'd0, 9'd0}, 1'b1, '{16'sd0, 14'sd0, 16'sd0, 1'b0}},
        '{'{CMD_MOVE, 11'd2047, 12'd4095, 9'd511}, 1'b0, '{16'sd0, 14'sd0, 16'sd0, 1'b0}},
        '{'{CMD_MOVE, 11'd0, 12'd0, 9'd0}, 1'b0, '{16'sd0, 14'sd0, 16'sd0, 1'b0}},
        '{'{CMD_MOVE, 11'd2047, 12'd0, 9'd0}, 1'b0, '{16'sd0, 14'sd0, 16'sd0, 1'b0}},
        '{'{CMD_MOVE, 11'd0, 12'd0, 9'd255}, 1'b0, '{16'sd0, 14'sd0, 16'sd0, 1'b0}},
        '{'{CMD_MOVE, 11'd0, 12'd4095, 9'd100}, 1'b0, '{16'sd0, 14'sd0, 16'sd0, 1'b0}},
        '{'{CMD_MOVE, 11'd0, 12'd4095, 9'd300}, 1'b0, '{16'sd0, 14'sd0, 16'sd0, 1'b0}},
        '{'{CMD_SET_POSE, 11'd1024, 12'd2048, 9'd157}, 1'b1, '{16'sd0, 14'sd0, 16'sd0, 1'b0}},
        '{'{CMD_MOVE, 11'd1024, 12'd2048, 9'd157}, 1'b0, '{16'sd0, 14'sd0, 16'sd0, 1'b0}},
        '{'{CMD_MOVE, 11'd1023, 12'd2049, 9'd471}, 1'b0, '{16'sd0, 14'sd0, 16'sd0, 1'b0}},
        '{'{CMD_MOVE, 11'd1, 12'd1, 9'd1}, 1'b0, '{16'sd0, 14'sd0, 16'sd0, 1'b0}},
        '{'{CMD_SET_POSE, 11'd1365, 12'd2730, 9'd341}, 1'b1, '{16'sd0, 14'sd0, 16'sd0, 1'b0}},
        '{'{CMD_MOVE, 11'd682, 12'd1365, 9'd170}, 1'b0, '{16'sd0, 14'sd0, 16'sd0, 1'b0}},
        '{'{CMD_MOVE, 11'd2047, 12'd0, 9'd511}, 1'b0, '{16'sd0, 14'sd0, 16'sd0, 1'b0}},
        '{'{CMD_MOVE, 11'd0, 12'd4095, 9'd0}, 1'b0, '{16'sd0, 14'sd0, 16'sd0, 1'b0}},
        '{'{CMD_SET_POSE, 11'd0, 12'd0, 9'd471}, 1'b1, '{16'sd0, 14'sd0, 16'sd0, 1'b0}},
        '{'{CMD_MOVE, 11'd0, 12'd0, 9'd471}, 1'b0, '{16'sd0, 14'sd0, 16'sd0, 1'b0}}
    };

    waypoint_turn_drive_turn_planner dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_target_x       (i_target_x),
        .i_target_y       (i_target_y),
        .i_target_heading (i_target_heading),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_first_turn     (o_first_turn),
        .o_travel_distance(o_travel_distance),
        .o_second_turn    (o_second_turn),
        .o_will_move      (o_will_move)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hundredths of a radian to a 16-bit binary angle, rounded.
    function automatic logic [15:0] heading_to_angle(input logic [H_W-1:0] h);
        longint prod;
        prod = longint'(h) * 6835653 + 32768;
        return prod[31:16];
    endfunction

    // Floor of the square root, one result bit per pass.
    function automatic int unsigned root_floor(input int unsigned n);
        int unsigned rem;
        int unsigned res;
        int unsigned bitv;
        rem = n;
        res = 0;
        bitv = 32'h4000_0000;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Direction of the move as a binary angle in [0, 2*pi).
    function automatic logic [15:0] trajectory_angle(input longint dx, input longint dy);
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        logic [31:0] z;
        logic [32:0] rounded;
        if (dx == 0) return (dy > 0) ? QUARTER_TURN : THREE_QUARTER_TURN;
        x = dx * 65536;
        y = dy * 65536;
        z = '0;
        // Left half plane: pre-rotate by a half turn.
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN_32;
        end
        // Vectoring pass: drive y to zero and sum the rotations.
        for (int i = 0; i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys;
                y -= xs;
                z += ARC_STEP[i];
            end else begin
                x -= ys;
                y += xs;
                z -= ARC_STEP[i];
            end
        end
        rounded = {1'b0, z} + 33'd32768;
        return rounded[31:16];
    endfunction

    // Plan for one accepted request; advances the predictor pose.
    function automatic t_plan plan_waypoint(input t_waypoint wp);
        t_plan       p;
        logic [15:0] want;
        logic [15:0] traj;
        logic [15:0] diff;
        logic [15:0] t1_bits;
        logic [15:0] t2;
        longint      dx;
        longint      dy;
        int          span;
        int          t1;
        want = heading_to_angle(wp.heading);
        if (wp.cmd == CMD_SET_POSE) begin
            pose_x = wp.x;
            pose_y = wp.y;
            pose_heading = want;
            p.first_turn = '0;
            p.travel_distance = '0;
            p.second_turn = '0;
            p.will_move = 1'b0;
            return p;
        end
        dx = longint'(wp.x) - longint'(pose_x);
        dy = longint'(wp.y) - longint'(pose_y);
        span = int'(root_floor(32'(dx * dx + dy * dy)));
        traj = trajectory_angle(dx, dy);
        diff = traj - pose_heading;
        t1 = int'($signed(diff));
        // At or past a quarter turn either way, turn the other way and drive backward.
        if (t1 >= QUARTER) begin
            t1 -= HALF;
            span = -span;
        end else if (t1 <= -QUARTER) begin
            t1 += HALF;
            span = -span;
        end
        t1_bits = t1[15:0];
        t2 = want - t1_bits - pose_heading;
        p.first_turn = t1_bits;
        p.travel_distance = span[DIST_W-1:0];
        p.second_turn = t2;
        p.will_move = (t1 != 0) || (span != 0) || (t2 != 0);
        pose_x = wp.x;
        pose_y = wp.y;
        pose_heading = want;
        return p;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Offer one request, wait for it to be taken, then queue its plan.
    task automatic submit(input t_stim_row row);
        t_plan predicted;
        @(negedge i_clk);
        if (!calm) begin
            while ($urandom_range(99) < 37) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_cmd <= row.wp.cmd;
        i_target_x <= row.wp.x;
        i_target_y <= row.wp.y;
        i_target_heading <= row.wp.heading;
        do @(posedge i_clk); while (o_stall);
        predicted = plan_waypoint(row.wp);
        planned_q.push_back(row.typed ? row.plan : predicted);
    endtask

    // Sender pause until every queued plan has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (planned_q.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls, calm stretches and long hold-offs on request.
    initial begin : receiver
        forever begin
            @(negedge i_clk);
            if (holds_done != holds_asked) begin
                holds_done++;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_stall <= calm ? 1'b0 : ($urandom_range(99) < 37);
        end
    end

    // Compare each accepted result with the oldest queued plan.
    always @(posedge i_clk) begin : result_check
        t_plan want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (planned_q.size() == 0) begin
                $error("result with no request pending");
                mismatches++;
            end else begin
                want = planned_q.pop_front();
                check_field("first_turn", want.first_turn, o_first_turn);
                check_field("travel_distance", want.travel_distance, o_travel_distance);
                check_field("second_turn", want.second_turn, o_second_turn);
                check_field("will_move", want.will_move, o_will_move);
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[waypoint_turn_drive_turn_planner] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Request side: reset, directed table, then random waypoints.
    initial begin : stimulus
        t_stim_row row;
        int        kind;
        int        nx;
        int        ny;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) submit(directed_rows[i]);

        row.typed = 1'b0;
        row.plan = directed_rows[5].plan;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            // Pressure points: long receiver hold-off, sender drains, calm stretch.
            if (n == 300 || n == 900) holds_asked++;
            if (n == 600 || n == 1100) drain_results();
            calm = (n >= 1150 && n < 1300);

            kind = $urandom_range(99);
            row.wp.heading = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 9'd511 : 9'd0)
                                                      : 9'($urandom_range(511));
            if (kind < 12) begin
                row.wp.cmd = CMD_SET_POSE;
                row.wp.x = 11'($urandom_range(2047));
                row.wp.y = 12'($urandom_range(4095));
            end else begin
                row.wp.cmd = CMD_MOVE;
                nx = $urandom_range(2047);
                ny = $urandom_range(4095);
                case ($urandom_range(5))
                    // Short hop around the current point.
                    1: begin
                        nx = int'(pose_x) + int'($urandom_range(16)) - 8;
                        ny = int'(pose_y) + int'($urandom_range(16)) - 8;
                    end
                    // Vertical move.
                    2: nx = pose_x;
                    // Horizontal move.
                    3: ny = pose_y;
                    // Zero move.
                    4: begin
                        nx = pose_x;
                        ny = pose_y;
                    end
                    default: ;
                endcase
                if (nx < 0) nx = 0;
                if (nx > 2047) nx = 2047;
                if (ny < 0) ny = 0;
                if (ny > 4095) ny = 4095;
                row.wp.x = 11'(nx);
                row.wp.y = 12'(ny);
            end
            submit(row);
        end
        calm = 1'b0;

        // Let everything drain, then give the block its latency once more.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[waypoint_turn_drive_turn_planner] OK");
        end else begin
            $display("[waypoint_turn_drive_turn_planner] ERROR");
        end
        $finish;
    end

endmodule
